[hdl/mfmc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfmc_pkg
// Shared types and constants of the max-flow / min-cut engine: item layouts,
// function and status codes, and the control and status bundles between top and engine.
// ----------------------------------------------------------------------------
package mfmc_pkg;

   localparam int NODE_W   = 10;
   localparam int CAP_IN_W = 32;
   localparam int IDX_W    = 12;
   localparam int FLOW_W   = 48;
   localparam int FUNC_W   = 2;
   localparam int STAT_W   = 2;

   // function codes
   localparam logic [FUNC_W-1:0] FN_ADD   = 2'd0;
   localparam logic [FUNC_W-1:0] FN_SOLVE = 2'd1;
   localparam logic [FUNC_W-1:0] FN_READ  = 2'd2;
   localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd3;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STAT_W-1:0] ST_NO_EDGE = 2'd2;

   localparam logic [FLOW_W-1:0] FLOW_SAT = {FLOW_W{1'b1}};

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [NODE_W-1:0]   from_node;
      logic [NODE_W-1:0]   to_node;
      logic [CAP_IN_W-1:0] capacity;
      logic [IDX_W-1:0]    edge_index;
   } req_item_type;

   typedef struct packed {
      logic [STAT_W-1:0]   status;
      logic [FLOW_W-1:0]   flow_value;
      logic [NODE_W-1:0]   edge_tail;
      logic [NODE_W-1:0]   edge_head;
      logic [CAP_IN_W-1:0] edge_flow;
      logic                in_cut;
   } rsp_item_type;

   typedef struct packed {
      logic         start;
      logic         out_free;
      req_item_type item;
   } eng_ctl_type;

   typedef struct packed {
      logic         idle;
      logic         done;
      rsp_item_type result;
   } eng_sts_type;

endpackage
`default_nettype wire

[hdl/mfmc_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfmc_if
// Valid/ready channels of the engine: request items in, response items out.
// ----------------------------------------------------------------------------
interface mfmc_req_if;
   import mfmc_pkg::*;
   logic         valid;
   logic         ready;
   req_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface mfmc_rsp_if;
   import mfmc_pkg::*;
   logic         valid;
   logic         ready;
   rsp_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[hdl/mfmc_alu.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfmc_alu
// Shared add/subtract unit: residuals, bottleneck compares, flow updates and
// the saturating flow sum all pass through it. Top bit is carry or borrow.
// ----------------------------------------------------------------------------
module mfmc_alu #(
   parameter int W = 48
) (
   input  mfmc_pkg::alu_op_type op,
   input  logic [W-1:0]         x,
   input  logic [W-1:0]         y,
   output logic [W:0]           r
);
   import mfmc_pkg::*;

   always_comb begin
      unique case (op)
         ALU_ADD: r = {1'b0, x} + {1'b0, y};
         ALU_SUB: r = {1'b0, x} - {1'b0, y};
         default: r = '0;
      endcase
   end

endmodule
`default_nettype wire

[hdl/mfmc_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfmc_seq
// Graph stores and the sequencer that walks them: edge loading, edge reads,
// graph clearing, and Dinic phases (level sweep, BFS, DFS with cursors and a
// path stack, bottleneck and flow update through the shared ALU).
// ----------------------------------------------------------------------------
module mfmc_seq #(
   parameter int MAX_NODES = 1024,
   parameter int MAX_EDGES = 4096,
   parameter int CAP_BITS  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [mfmc_pkg::NODE_W-1:0]   node_count,
   input  mfmc_pkg::eng_ctl_type         ctl,
   output mfmc_pkg::eng_sts_type         sts
);
   import mfmc_pkg::*;

   localparam int NW  = $clog2(MAX_NODES);
   localparam int CW  = NW + 1;
   localparam int LW  = NW + 1;
   localparam int PW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ECW = $clog2(MAX_EDGES + 1);
   localparam int EW  = PW + 1;
   localparam int KW  = EW + 1;
   localparam int AW  = (CAP_BITS > FLOW_W) ? CAP_BITS : FLOW_W;
   localparam logic [LW-1:0] LEVEL_NONE = {LW{1'b1}};
   localparam logic [KW-1:0] LINK_NONE  = {1'b1, {EW{1'b0}}};

   typedef enum logic [35:0] {
      S_IDLE = 36'd1 << 0,  S_SWA  = 36'd1 << 1,  S_SWB  = 36'd1 << 2,
      S_ADDW = 36'd1 << 3,  S_LKR  = 36'd1 << 4,  S_LKW  = 36'd1 << 5,
      S_LKL  = 36'd1 << 6,  S_RDE  = 36'd1 << 7,  S_RDT  = 36'd1 << 8,
      S_RDH  = 36'd1 << 9,  S_RDC  = 36'd1 << 10, S_BINI = 36'd1 << 11,
      S_BQR  = 36'd1 << 12, S_BQX  = 36'd1 << 13, S_BQF  = 36'd1 << 14,
      S_BEC  = 36'd1 << 15, S_BED  = 36'd1 << 16, S_BEL  = 36'd1 << 17,
      S_BTR  = 36'd1 << 18, S_BTC  = 36'd1 << 19, S_DTOP = 36'd1 << 20,
      S_DCUR = 36'd1 << 21, S_DCHK = 36'd1 << 22, S_DD   = 36'd1 << 23,
      S_DL   = 36'd1 << 24, S_RTS  = 36'd1 << 25, S_RTT  = 36'd1 << 26,
      S_RTC  = 36'd1 << 27, S_RTN  = 36'd1 << 28, S_AGS  = 36'd1 << 29,
      S_AGD  = 36'd1 << 30, S_AGM  = 36'd1 << 31, S_UPS  = 36'd1 << 32,
      S_UPD  = 36'd1 << 33, S_SUM  = 36'd1 << 34, S_FIN  = 36'd1 << 35
   } state_type;

   function automatic logic node_ok(input logic [NODE_W-1:0] v, input logic [31:0] lim);
      return 32'(v) <= lim;
   endfunction

   // memories
   logic [NODE_W-1:0]   tail_mem   [MAX_EDGES];
   logic [NODE_W-1:0]   head_mem   [MAX_EDGES];
   logic [CAP_BITS-1:0] cap_mem    [MAX_EDGES];
   logic [CAP_BITS-1:0] flow_mem   [MAX_EDGES];
   logic [KW-1:0]       link_mem   [2*MAX_EDGES];
   logic [KW-1:0]       first_mem  [MAX_NODES];
   logic [KW-1:0]       last_mem   [MAX_NODES];
   logic [LW-1:0]       level_mem  [MAX_NODES];
   logic [KW-1:0]       cursor_mem [MAX_NODES];
   logic [NW-1:0]       queue_mem  [MAX_NODES];
   logic [EW-1:0]       stack_mem  [MAX_NODES];

   logic [NODE_W-1:0]   tail_rd_ff, head_rd_ff;
   logic [CAP_BITS-1:0] cap_rd_ff, flow_rd_ff;
   logic [KW-1:0]       link_rd_ff, first_rd_ff, last_rd_ff, cursor_rd_ff;
   logic [LW-1:0]       level_rd_ff;
   logic [NW-1:0]       queue_rd_ff;
   logic [EW-1:0]       stack_rd_ff;

   // memory port controls
   logic [PW-1:0]       pa;
   logic                pair_we, flow_we;
   logic [CAP_BITS-1:0] flow_wd;
   logic [EW-1:0]       la;
   logic                link_we;
   logic [KW-1:0]       link_wd;
   logic [NW-1:0]       fa;
   logic                first_we, last_we;
   logic [KW-1:0]       first_wd;
   logic [NW-1:0]       va;
   logic                level_we;
   logic [LW-1:0]       level_wd;
   logic [NW-1:0]       ca;
   logic                cursor_we;
   logic [KW-1:0]       cursor_wd;
   logic [NW-1:0]       qa;
   logic                queue_we;
   logic [NW-1:0]       queue_wd;
   logic [NW-1:0]       sa;
   logic                stack_we;
   logic [EW-1:0]       stack_wd;

   // sequencer registers
   state_type           st_ff, st_in;
   logic [ECW-1:0]      edges_ff, edges_in;
   logic                boot_ff, boot_in;
   logic                sw_clr_ff, sw_clr_in;
   logic [NW-1:0]       sw_ff, sw_in;
   logic                bad_ff, bad_in;
   logic [NODE_W-1:0]   a_ff, a_in, b_ff, b_in;
   logic [CAP_BITS-1:0] cap_ff, cap_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                side_ff, side_in;
   logic [NW-1:0]       nd_ff, nd_in;
   logic [KW-1:0]       id_ff, id_in;
   logic [KW-1:0]       nxt_ff, nxt_in;
   logic [NW-1:0]       cur_ff, cur_in;
   logic [LW-1:0]       lvc_ff, lvc_in;
   logic [NODE_W-1:0]   hd_ff, hd_in;
   logic                rnz_ff, rnz_in;
   logic                tok_ff, tok_in, hok_ff, hok_in, tin_ff, tin_in;
   logic [CW-1:0]       depth_ff, depth_in;
   logic [CW-1:0]       qh_ff, qh_in, qt_ff, qt_in;
   logic [CW-1:0]       k_ff, k_in;
   logic [CAP_BITS-1:0] bn_ff, bn_in, r_ff, r_in;
   logic [FLOW_W-1:0]   sum_ff, sum_in;
   logic [EW-1:0]       e_ff, e_in;
   rsp_item_type        res_ff, res_in;

   logic [31:0]         lim;
   alu_op_type          alu_op;
   logic [AW-1:0]       alu_x, alu_y;
   logic [AW:0]         alu_r;
   logic                do_ret, do_adv, do_lnk;
   logic [KW-1:0]       adv_id;
   logic [NODE_W-1:0]   ent_head, ent_tail;
   logic                ent_rnz;
   logic [LW-1:0]       lvc_inc;
   logic [CW-1:0]       k_inc;

   mfmc_alu #(.W(AW)) u_alu (.op(alu_op), .x(alu_x), .y(alu_y), .r(alu_r));

   // valid node limit
   always_comb begin
      lim = (32'(node_count) < 32'(MAX_NODES)) ? 32'(node_count) : 32'(MAX_NODES - 1);
   end

   // entry view of the pair just read
   always_comb begin
      ent_head = id_ff[0] ? tail_rd_ff : head_rd_ff;
      ent_tail = e_ff[0] ? head_rd_ff : tail_rd_ff;
      ent_rnz  = id_ff[0] ? (flow_rd_ff != '0) : (cap_rd_ff != flow_rd_ff);
      lvc_inc  = LW'(lvc_ff + LW'(1));
      k_inc    = CW'(k_ff + CW'(1));
   end

   // memories, single port with registered read
   always_ff @(posedge clock) begin
      if (pair_we) begin
         tail_mem[pa] <= a_ff;
         head_mem[pa] <= b_ff;
         cap_mem[pa]  <= cap_ff;
      end
      if (flow_we) flow_mem[pa] <= flow_wd;
      tail_rd_ff <= tail_mem[pa];
      head_rd_ff <= head_mem[pa];
      cap_rd_ff  <= cap_mem[pa];
      flow_rd_ff <= flow_mem[pa];
   end

   always_ff @(posedge clock) begin
      if (link_we) link_mem[la] <= link_wd;
      link_rd_ff <= link_mem[la];
   end

   always_ff @(posedge clock) begin
      if (first_we) first_mem[fa] <= first_wd;
      if (last_we) last_mem[fa] <= id_ff;
      first_rd_ff <= first_mem[fa];
      last_rd_ff  <= last_mem[fa];
   end

   always_ff @(posedge clock) begin
      if (level_we) level_mem[va] <= level_wd;
      level_rd_ff <= level_mem[va];
   end

   always_ff @(posedge clock) begin
      if (cursor_we) cursor_mem[ca] <= cursor_wd;
      cursor_rd_ff <= cursor_mem[ca];
   end

   always_ff @(posedge clock) begin
      if (queue_we) queue_mem[qa] <= queue_wd;
      queue_rd_ff <= queue_mem[qa];
   end

   always_ff @(posedge clock) begin
      if (stack_we) stack_mem[sa] <= stack_wd;
      stack_rd_ff <= stack_mem[sa];
   end

   // sequencer
   always_comb begin
      st_in = st_ff;       edges_in = edges_ff;   boot_in = boot_ff;
      sw_clr_in = sw_clr_ff; sw_in = sw_ff;       bad_in = bad_ff;
      a_in = a_ff;         b_in = b_ff;           cap_in = cap_ff;
      idx_in = idx_ff;     side_in = side_ff;     nd_in = nd_ff;
      id_in = id_ff;       nxt_in = nxt_ff;       cur_in = cur_ff;
      lvc_in = lvc_ff;     hd_in = hd_ff;         rnz_in = rnz_ff;
      tok_in = tok_ff;     hok_in = hok_ff;       tin_in = tin_ff;
      depth_in = depth_ff; qh_in = qh_ff;         qt_in = qt_ff;
      k_in = k_ff;         bn_in = bn_ff;         r_in = r_ff;
      sum_in = sum_ff;     e_in = e_ff;           res_in = res_ff;

      pa = '0; pair_we = 1'b0; flow_we = 1'b0; flow_wd = '0;
      la = '0; link_we = 1'b0; link_wd = '0;
      fa = '0; first_we = 1'b0; last_we = 1'b0; first_wd = '0;
      va = '0; level_we = 1'b0; level_wd = '0;
      ca = '0; cursor_we = 1'b0; cursor_wd = '0;
      qa = '0; queue_we = 1'b0; queue_wd = '0;
      sa = '0; stack_we = 1'b0; stack_wd = '0;
      alu_op = ALU_ADD; alu_x = '0; alu_y = '0;
      do_ret = 1'b0; do_adv = 1'b0; do_lnk = 1'b0; adv_id = nxt_ff;

      unique case (st_ff)
         S_IDLE: begin
            if (ctl.start) begin
               a_in   = ctl.item.from_node;
               b_in   = ctl.item.to_node;
               cap_in = CAP_BITS'(ctl.item.capacity);
               idx_in = ctl.item.edge_index;
               res_in = '0;
               unique case (ctl.item.func)
                  FN_ADD: begin
                     if (32'(edges_ff) >= 32'(MAX_EDGES)) begin
                        res_in.status = ST_FULL;
                        st_in = S_FIN;
                     end else begin
                        st_in = S_ADDW;
                     end
                  end
                  FN_SOLVE: begin
                     bad_in = !node_ok(ctl.item.from_node, lim) ||
                              !node_ok(ctl.item.to_node, lim) ||
                              (ctl.item.from_node == ctl.item.to_node);
                     sum_in = '0;
                     sw_clr_in = 1'b0;
                     sw_in = '0;
                     st_in = S_SWA;
                  end
                  FN_READ: begin
                     if (32'(ctl.item.edge_index) >= 32'(edges_ff) ||
                         32'(ctl.item.edge_index) >= 32'(MAX_EDGES)) begin
                        res_in.status = ST_NO_EDGE;
                        st_in = S_FIN;
                     end else begin
                        st_in = S_RDE;
                     end
                  end
                  FN_CLEAR: begin
                     sw_clr_in = 1'b1;
                     sw_in = '0;
                     st_in = S_SWA;
                  end
                  default: st_in = S_IDLE;
               endcase
            end
         end

         // node sweep: levels unreached, cursors from first links, or graph clear
         S_SWA: begin
            fa = sw_ff;
            first_we = sw_clr_ff;
            first_wd = LINK_NONE;
            va = sw_ff;
            level_we = 1'b1;
            level_wd = LEVEL_NONE;
            st_in = S_SWB;
         end
         S_SWB: begin
            ca = sw_ff;
            cursor_we = 1'b1;
            cursor_wd = first_rd_ff;
            if (32'(sw_ff) == 32'(MAX_NODES - 1)) begin
               if (sw_clr_ff) begin
                  edges_in = '0;
                  sum_in = '0;
                  boot_in = 1'b0;
                  st_in = boot_ff ? S_IDLE : S_FIN;
               end else if (bad_ff) begin
                  res_in.flow_value = '0;
                  st_in = S_FIN;
               end else begin
                  st_in = S_BINI;
               end
            end else begin
               sw_in = NW'(sw_ff + NW'(1));
               st_in = S_SWA;
            end
         end

         // edge add: pair stores, then link each end into its node list
         S_ADDW: begin
            pa = PW'(edges_ff);
            pair_we = 1'b1;
            flow_we = 1'b1;
            flow_wd = '0;
            side_in = 1'b0;
            if (32'(a_ff) < 32'(MAX_NODES)) begin
               nd_in = NW'(a_ff);
               id_in = {1'b0, PW'(edges_ff), 1'b0};
               st_in = S_LKR;
            end else begin
               do_lnk = 1'b1;
            end
         end
         S_LKR: begin
            fa = nd_ff;
            st_in = S_LKW;
         end
         S_LKW: begin
            la = id_ff[EW-1:0];
            link_we = 1'b1;
            link_wd = LINK_NONE;
            fa = nd_ff;
            first_we = first_rd_ff[KW-1];
            first_wd = id_ff;
            last_we = 1'b1;
            nxt_in = last_rd_ff;
            if (first_rd_ff[KW-1]) do_lnk = 1'b1;
            else st_in = S_LKL;
         end
         S_LKL: begin
            la = nxt_ff[EW-1:0];
            link_we = 1'b1;
            link_wd = id_ff;
            do_lnk = 1'b1;
         end

         // edge read and cut test
         S_RDE: begin
            pa = PW'(idx_ff);
            st_in = S_RDT;
         end
         S_RDT: begin
            res_in.edge_tail = tail_rd_ff;
            res_in.edge_head = head_rd_ff;
            res_in.edge_flow = CAP_IN_W'(flow_rd_ff);
            hd_in  = head_rd_ff;
            tok_in = node_ok(tail_rd_ff, lim);
            hok_in = node_ok(head_rd_ff, lim);
            va = NW'(tail_rd_ff);
            st_in = S_RDH;
         end
         S_RDH: begin
            tin_in = tok_ff && (level_rd_ff != LEVEL_NONE);
            va = NW'(hd_ff);
            st_in = S_RDC;
         end
         S_RDC: begin
            res_in.in_cut = tin_ff && hok_ff && (level_rd_ff == LEVEL_NONE);
            st_in = S_FIN;
         end

         // breadth-first level build
         S_BINI: begin
            va = NW'(a_ff);
            level_we = 1'b1;
            level_wd = '0;
            qa = '0;
            queue_we = 1'b1;
            queue_wd = NW'(a_ff);
            qh_in = '0;
            qt_in = CW'(1);
            st_in = S_BQR;
         end
         S_BQR: begin
            if (qh_ff == qt_ff) begin
               st_in = S_BTR;
            end else begin
               qa = NW'(qh_ff);
               qh_in = CW'(qh_ff + CW'(1));
               st_in = S_BQX;
            end
         end
         S_BQX: begin
            cur_in = queue_rd_ff;
            fa = queue_rd_ff;
            va = queue_rd_ff;
            st_in = S_BQF;
         end
         S_BQF: begin
            lvc_in = level_rd_ff;
            id_in = first_rd_ff;
            st_in = S_BEC;
         end
         S_BEC: begin
            if (id_ff[KW-1]) begin
               st_in = S_BQR;
            end else begin
               pa = id_ff[EW-1:1];
               la = id_ff[EW-1:0];
               st_in = S_BED;
            end
         end
         S_BED: begin
            hd_in  = ent_head;
            rnz_in = ent_rnz;
            nxt_in = link_rd_ff;
            if (node_ok(ent_head, lim)) begin
               va = NW'(ent_head);
               st_in = S_BEL;
            end else begin
               id_in = link_rd_ff;
               st_in = S_BEC;
            end
         end
         S_BEL: begin
            va = NW'(hd_ff);
            if ((level_rd_ff == LEVEL_NONE) && rnz_ff) begin
               level_we = 1'b1;
               level_wd = lvc_inc;
               if (32'(qt_ff) < 32'(MAX_NODES)) begin
                  qa = NW'(qt_ff);
                  queue_we = 1'b1;
                  queue_wd = NW'(hd_ff);
                  qt_in = CW'(qt_ff + CW'(1));
               end
            end
            id_in = nxt_ff;
            st_in = S_BEC;
         end
         S_BTR: begin
            va = NW'(b_ff);
            st_in = S_BTC;
         end
         S_BTC: begin
            if (level_rd_ff == LEVEL_NONE) begin
               res_in.flow_value = sum_ff;
               st_in = S_FIN;
            end else begin
               cur_in = NW'(a_ff);
               depth_in = '0;
               st_in = S_DTOP;
            end
         end

         // depth-first blocking flow search
         S_DTOP: begin
            if (cur_ff == NW'(b_ff)) begin
               k_in = '0;
               sa = '0;
               st_in = S_AGS;
            end else begin
               ca = cur_ff;
               va = cur_ff;
               st_in = S_DCUR;
            end
         end
         S_DCUR: begin
            id_in = cursor_rd_ff;
            lvc_in = level_rd_ff;
            st_in = S_DCHK;
         end
         S_DCHK: begin
            if (id_ff[KW-1]) begin
               do_ret = 1'b1;
            end else begin
               pa = id_ff[EW-1:1];
               la = id_ff[EW-1:0];
               st_in = S_DD;
            end
         end
         S_DD: begin
            hd_in  = ent_head;
            rnz_in = ent_rnz;
            nxt_in = link_rd_ff;
            if (node_ok(ent_head, lim)) begin
               va = NW'(ent_head);
               st_in = S_DL;
            end else begin
               adv_id = link_rd_ff;
               do_adv = 1'b1;
            end
         end
         S_DL: begin
            if ((level_rd_ff != LEVEL_NONE) && (level_rd_ff == lvc_inc) && rnz_ff) begin
               if (32'(depth_ff) < 32'(MAX_NODES)) begin
                  sa = NW'(depth_ff);
                  stack_we = 1'b1;
                  stack_wd = id_ff[EW-1:0];
                  depth_in = CW'(depth_ff + CW'(1));
                  cur_in = NW'(hd_ff);
                  st_in = S_DTOP;
               end else begin
                  do_ret = 1'b1;
               end
            end else begin
               do_adv = 1'b1;
            end
         end

         // retreat: pop an entry and step its tail's cursor
         S_RTS: begin
            e_in = stack_rd_ff;
            pa = stack_rd_ff[EW-1:1];
            st_in = S_RTT;
         end
         S_RTT: begin
            cur_in = NW'(ent_tail);
            ca = NW'(ent_tail);
            st_in = S_RTC;
         end
         S_RTC: begin
            if (cursor_rd_ff[KW-1]) begin
               st_in = S_DTOP;
            end else begin
               la = cursor_rd_ff[EW-1:0];
               st_in = S_RTN;
            end
         end
         S_RTN: begin
            ca = cur_ff;
            cursor_we = 1'b1;
            cursor_wd = link_rd_ff;
            st_in = S_DTOP;
         end

         // augment: bottleneck over the stack
         S_AGS: begin
            e_in = stack_rd_ff;
            pa = stack_rd_ff[EW-1:1];
            st_in = S_AGD;
         end
         S_AGD: begin
            if (e_ff[0]) begin
               alu_op = ALU_ADD;
               alu_x = AW'(flow_rd_ff);
               alu_y = '0;
            end else begin
               alu_op = ALU_SUB;
               alu_x = AW'(cap_rd_ff);
               alu_y = AW'(flow_rd_ff);
            end
            r_in = alu_r[CAP_BITS-1:0];
            st_in = S_AGM;
         end
         S_AGM: begin
            alu_op = ALU_SUB;
            alu_x = AW'(r_ff);
            alu_y = AW'(bn_ff);
            if ((k_ff == '0) || alu_r[AW]) bn_in = r_ff;
            if (k_inc < depth_ff) begin
               k_in = k_inc;
               sa = NW'(k_inc);
               st_in = S_AGS;
            end else begin
               k_in = '0;
               sa = '0;
               st_in = S_UPS;
            end
         end

         // augment: flow update along the stack
         S_UPS: begin
            e_in = stack_rd_ff;
            pa = stack_rd_ff[EW-1:1];
            st_in = S_UPD;
         end
         S_UPD: begin
            pa = e_ff[EW-1:1];
            alu_op = e_ff[0] ? ALU_SUB : ALU_ADD;
            alu_x = AW'(flow_rd_ff);
            alu_y = AW'(bn_ff);
            flow_we = 1'b1;
            flow_wd = alu_r[CAP_BITS-1:0];
            if (k_inc < depth_ff) begin
               k_in = k_inc;
               sa = NW'(k_inc);
               st_in = S_UPS;
            end else begin
               st_in = S_SUM;
            end
         end
         S_SUM: begin
            alu_op = ALU_ADD;
            alu_x = AW'(sum_ff);
            alu_y = AW'(bn_ff);
            sum_in = (|alu_r[AW:FLOW_W]) ? FLOW_SAT : alu_r[FLOW_W-1:0];
            cur_in = NW'(a_ff);
            depth_in = '0;
            st_in = S_DTOP;
         end

         S_FIN: begin
            if (ctl.out_free) st_in = S_IDLE;
         end

         default: st_in = S_IDLE;
      endcase

      // cursor advance to the next link of the current node
      if (do_adv) begin
         id_in = adv_id;
         ca = cur_ff;
         cursor_we = 1'b1;
         cursor_wd = adv_id;
         st_in = S_DCHK;
      end

      // retreat or end of phase
      if (do_ret) begin
         if (depth_ff == '0) begin
            sw_in = '0;
            sw_clr_in = 1'b0;
            bad_in = 1'b0;
            st_in = S_SWA;
         end else begin
            depth_in = CW'(depth_ff - CW'(1));
            sa = NW'(depth_ff - CW'(1));
            st_in = S_RTS;
         end
      end

      // link the head end next, or finish the add
      if (do_lnk) begin
         if (!side_ff && (32'(b_ff) < 32'(MAX_NODES))) begin
            side_in = 1'b1;
            nd_in = NW'(b_ff);
            id_in = {1'b0, PW'(edges_ff), 1'b1};
            st_in = S_LKR;
         end else begin
            edges_in = ECW'(edges_ff + ECW'(1));
            st_in = S_FIN;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= S_SWA;
         edges_ff  <= '0;
         boot_ff   <= 1'b1;
         sw_clr_ff <= 1'b1;
         sw_ff     <= '0;
         bad_ff    <= 1'b0;
      end else begin
         st_ff     <= st_in;
         edges_ff  <= edges_in;
         boot_ff   <= boot_in;
         sw_clr_ff <= sw_clr_in;
         sw_ff     <= sw_in;
         bad_ff    <= bad_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      a_ff <= a_in;         b_ff <= b_in;         cap_ff <= cap_in;
      idx_ff <= idx_in;     side_ff <= side_in;   nd_ff <= nd_in;
      id_ff <= id_in;       nxt_ff <= nxt_in;     cur_ff <= cur_in;
      lvc_ff <= lvc_in;     hd_ff <= hd_in;       rnz_ff <= rnz_in;
      tok_ff <= tok_in;     hok_ff <= hok_in;     tin_ff <= tin_in;
      depth_ff <= depth_in; qh_ff <= qh_in;       qt_ff <= qt_in;
      k_ff <= k_in;         bn_ff <= bn_in;       r_ff <= r_in;
      sum_ff <= sum_in;     e_ff <= e_in;         res_ff <= res_in;
   end

   always_comb begin
      sts.idle   = (st_ff == S_IDLE);
      sts.done   = (st_ff == S_FIN);
      sts.result = res_ff;
   end

endmodule
`default_nettype wire

[hdl/max_flow_min_cut_engine_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// max_flow_min_cut_engine_top
// Dinic maximum-flow / minimum-cut engine over a loaded directed graph.
// ----------------------------------------------------------------------------
// One item is worked at a time and every item gives one response item. All
// graph state lives in single-port memories with registered reads, and the
// sequencer issues one access per memory per cycle. A solve runs phases;
// each phase opens with a node sweep, then builds levels breadth-first and
// searches depth-first, and augments along each path found. After reset the
// engine runs a clearing pass before it takes its first item; csr writes are
// taken throughout. A finished response waits in the output register while
// the next item is accepted.
module max_flow_min_cut_engine_top #(
   parameter int MAX_NODES = 1024,
   parameter int MAX_EDGES = 4096,
   parameter int CAP_BITS  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   mfmc_req_if.sink                      req_chan,
   mfmc_rsp_if.source                    rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [mfmc_pkg::NODE_W-1:0]   csr_wr_data
);
   import mfmc_pkg::*;

   logic [NODE_W-1:0] node_count_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_item_ff, rsp_item_in;
   eng_ctl_type       ctl;
   eng_sts_type       sts;
   logic              out_free;

   mfmc_seq #(
      .MAX_NODES(MAX_NODES),
      .MAX_EDGES(MAX_EDGES),
      .CAP_BITS (CAP_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .node_count(node_count_ff),
      .ctl       (ctl),
      .sts       (sts)
   );

   // node count register
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= '0;
      end else if (csr_wr_en) begin
         node_count_ff <= csr_wr_data;
      end
   end

   // request side
   always_comb begin
      out_free       = !rsp_valid_ff || rsp_chan.ready;
      req_chan.ready = sts.idle;
      ctl.start      = req_chan.valid && sts.idle;
      ctl.out_free   = out_free;
      ctl.item       = req_chan.payload;
   end

   // response output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (rsp_valid_ff && rsp_chan.ready) rsp_valid_in = 1'b0;
      if (sts.done && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = sts.result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_item_ff;

endmodule
`default_nettype wire
